>>> hdl/apwt_pkg.sv
// Shared constants, types and the range-exponent function for the
// autorange peak window tracker. No dependencies.
package apwt_pkg;

    localparam int HISTORY_DEPTH = 256;
    localparam int WINDOW        = 180;

    localparam int SAMPLE_W  = 32;
    localparam int EXP_W     = 6;
    localparam int RANGE_W   = 33;
    localparam int ADDR_W    = $clog2(HISTORY_DEPTH);
    localparam int AGE_W     = $clog2(WINDOW + 1);
    localparam int M_TDATA_W = ((EXP_W + RANGE_W + 7) / 8) * 8;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_IDX_LSB = 2;

    localparam logic REG_MANUAL_ENABLE = 1'b0;
    localparam logic REG_MANUAL_RANGE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    // Smallest e >= 1 with v <= 2^e.
    function automatic logic [EXP_W-1:0] exponent_for(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] vm1;
        logic [EXP_W-1:0]    e;
        vm1 = v - SAMPLE_W'(1);
        e   = EXP_W'(1);
        if (v > SAMPLE_W'(2)) begin
            for (int i = 1; i < SAMPLE_W; i++) begin
                if (vm1[i]) begin
                    e = EXP_W'(i + 1);
                end
            end
        end
        return e;
    endfunction

endpackage

>>> hdl/autorange_peak_window_tracker.sv
// Autorange peak window tracker: sample history memory, range/age update,
// window rescan sequencer, APB configuration and stream ports.
// Depends on apwt_pkg.
//
// One item yields one result. An item that causes no rescan goes from
// acceptance to result through accept, evaluate and store. An item whose
// hold age reaches WINDOW walks the WINDOW-1 newest stored samples through
// the single read port of the history memory, one entry per cycle, between
// evaluate and store. A new item is accepted once the previous one has been
// handed to the output register; the output register holds a result until
// m_tready, and a finished item waits for it only if it is still full.
// The history reads as zero after reset by way of per-entry valid bits; no
// clearing pass is needed.
module autorange_peak_window_tracker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [apwt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [apwt_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [apwt_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [apwt_pkg::SAMPLE_W-1:0]        s_tdata,   // sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [apwt_pkg::M_TDATA_W-1:0]       m_tdata,   // auto_exponent, effective_range, pad
    output logic [0:0]                           m_tuser    // rescanned
);
    import apwt_pkg::*;

    state_t                state_reg, state_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [SAMPLE_W-1:0]   best_reg, best_next;
    logic [AGE_W-1:0]      best_age_reg, best_age_next;
    logic [AGE_W-1:0]      cmp_k_reg, cmp_k_next;
    logic [ADDR_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0]     wp_reg, wp_next;
    logic [EXP_W-1:0]      exp_reg, exp_next;
    logic [AGE_W-1:0]      age_reg, age_next;
    logic                  upd_exp_reg, upd_exp_next;
    logic                  scan_reg, scan_next;
    logic                  man_en_reg, man_en_next;
    logic [SAMPLE_W-1:0]   man_range_reg, man_range_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [EXP_W-1:0]      out_exp_reg, out_exp_next;
    logic [RANGE_W-1:0]    out_range_reg, out_range_next;
    logic                  out_rescan_reg, out_rescan_next;

    logic [SAMPLE_W-1:0]   hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_valid_reg;

    logic                  cfg_we;
    logic                  reg_sel;
    logic                  out_free;
    logic                  exceeds;
    logic [AGE_W-1:0]      age_inc;
    logic [SAMPLE_W-1:0]   rd_value;
    logic [ADDR_W-1:0]     scan_idx_dec;
    logic [ADDR_W-1:0]     wp_inc;
    logic [EXP_W-1:0]      exp_new;
    logic                  mem_we;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign reg_sel  = paddr[CFG_IDX_LSB];
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_range_reg, out_exp_reg});
    assign m_tuser  = out_rescan_reg;

    always_comb begin
        case (reg_sel)
            REG_MANUAL_ENABLE: prdata = CFG_DATA_W'(man_en_reg);
            REG_MANUAL_RANGE:  prdata = CFG_DATA_W'(man_range_reg);
            default:           prdata = '0;
        endcase
    end

    assign exceeds      = {1'b0, sample_reg} > (RANGE_W'(1) << exp_reg);
    assign age_inc      = exceeds ? '0 : age_reg + AGE_W'(1);
    assign rd_value     = rd_valid_reg ? rd_data_reg : '0;
    assign scan_idx_dec = (scan_idx_reg == '0) ? ADDR_W'(HISTORY_DEPTH - 1)
                                               : scan_idx_reg - ADDR_W'(1);
    assign wp_inc       = (wp_reg == ADDR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                 : wp_reg + ADDR_W'(1);
    assign exp_new      = upd_exp_reg ? exponent_for(best_reg) : exp_reg;
    assign mem_we       = (state_reg == ST_FIN) && out_free;

    always_comb begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        best_next       = best_reg;
        best_age_next   = best_age_reg;
        cmp_k_next      = cmp_k_reg;
        scan_idx_next   = scan_idx_reg;
        wp_next         = wp_reg;
        exp_next        = exp_reg;
        age_next        = age_reg;
        upd_exp_next    = upd_exp_reg;
        scan_next       = scan_reg;
        man_en_next     = man_en_reg;
        man_range_next  = man_range_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_exp_next    = out_exp_reg;
        out_range_next  = out_range_reg;
        out_rescan_next = out_rescan_reg;

        if (cfg_we) begin
            case (reg_sel)
                REG_MANUAL_ENABLE: man_en_next    = pwdata[0];
                REG_MANUAL_RANGE:  man_range_next = pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next   = s_tdata;
                    scan_idx_next = wp_reg;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                age_next      = age_inc;
                best_next     = sample_reg;
                best_age_next = '0;
                upd_exp_next  = exceeds;
                scan_next     = 1'b0;
                if (age_inc == AGE_W'(WINDOW)) begin
                    // first history read (newest entry) issued this cycle
                    scan_next     = 1'b1;
                    upd_exp_next  = 1'b1;
                    cmp_k_next    = AGE_W'(1);
                    scan_idx_next = scan_idx_dec;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (rd_value > best_reg) begin
                    best_next     = rd_value;
                    best_age_next = cmp_k_reg;
                end
                if (cmp_k_reg == AGE_W'(WINDOW - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    cmp_k_next    = cmp_k_reg + AGE_W'(1);
                    scan_idx_next = scan_idx_dec;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    exp_next = exp_new;
                    if (scan_reg) begin
                        age_next = best_age_reg;
                    end
                    wp_next         = wp_inc;
                    m_tvalid_next   = 1'b1;
                    out_exp_next    = exp_new;
                    out_rescan_next = scan_reg;
                    if (man_en_reg) begin
                        out_range_next = (man_range_reg == '0) ? RANGE_W'(1)
                                                               : RANGE_W'(man_range_reg);
                    end else begin
                        out_range_next = RANGE_W'(1) << exp_new;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // walk reads and writes never overlap: writes happen only in ST_FIN, after any walk has ended
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wp_inc] <= sample_reg;
        end
        rd_data_reg  <= hist_mem[scan_idx_reg];
        rd_valid_reg <= valid_reg[scan_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[wp_inc] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            exp_reg        <= '0;
            age_reg        <= '0;
            upd_exp_reg    <= 1'b0;
            scan_reg       <= 1'b0;
            man_en_reg     <= 1'b0;
            man_range_reg  <= SAMPLE_W'(1);
            m_tvalid_reg   <= 1'b0;
            cmp_k_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            exp_reg        <= exp_next;
            age_reg        <= age_next;
            upd_exp_reg    <= upd_exp_next;
            scan_reg       <= scan_next;
            man_en_reg     <= man_en_next;
            man_range_reg  <= man_range_next;
            m_tvalid_reg   <= m_tvalid_next;
            cmp_k_reg      <= cmp_k_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        best_reg       <= best_next;
        best_age_reg   <= best_age_next;
        scan_idx_reg   <= scan_idx_next;
        out_exp_reg    <= out_exp_next;
        out_range_reg  <= out_range_next;
        out_rescan_reg <= out_rescan_next;
    end

    a_age_below_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (age_reg < AGE_W'(WINDOW)))
        else $error("hold age left at or above window");

    a_scan_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cmp_k_reg >= AGE_W'(1) && cmp_k_reg <= AGE_W'(WINDOW - 1)))
        else $error("scan position out of window");

    a_exp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_reg <= EXP_W'(SAMPLE_W))
        else $error("range exponent above 32");

    a_rescan_exp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_rescan_reg) |-> (out_exp_reg != '0))
        else $error("rescan produced range one");

    a_scan_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cmp_k_reg == AGE_W'(WINDOW - 1)) |=> (state_reg == ST_FIN))
        else $error("walk did not end after last entry");

endmodule
